// ===== src/pmq_pkg.sv =====
// pmq_pkg: field widths, command and status codes for the partitioned multi queue
// no dependencies; used by the channel interfaces and the top level

package pmq_pkg;

   localparam int CMD_WIDTH    = 2;
   localparam int QID_WIDTH    = 2;
   localparam int WORD_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_SHOW = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BADQ  = 2'd3
   } status_type;

endpackage

// ===== src/pmq_req_if.sv =====
// pmq_req_if: command channel, valid/ready handshake plus command word
// depends on pmq_pkg for field widths

interface pmq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pmq_pkg::CMD_WIDTH-1:0]  command;
   logic        [pmq_pkg::QID_WIDTH-1:0]  queue_id;
   logic signed [pmq_pkg::WORD_WIDTH-1:0] data_in;

   modport source (output valid, command, queue_id, data_in, input ready);
   modport sink   (input valid, command, queue_id, data_in, output ready);
endinterface

// ===== src/pmq_rsp_if.sv =====
// pmq_rsp_if: result channel, valid/ready handshake plus result word
// depends on pmq_pkg for field widths

interface pmq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pmq_pkg::STATUS_WIDTH-1:0] status;
   logic signed [pmq_pkg::WORD_WIDTH-1:0]   data_out;
   logic                                   last;

   modport source (output valid, status, data_out, last, input ready);
   modport sink   (input valid, status, data_out, last, output ready);
endinterface

// ===== src/pmq_store.sv =====
// pmq_store: shared data memory, one write port and one read port, registered read
// no dependencies

module pmq_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/partitioned_multi_queue_top.sv =====
// partitioned_multi_queue_top: linear queues in fixed segments of one shared memory
// depends on pmq_pkg, pmq_req_if, pmq_rsp_if, pmq_store
//
//   port      dir  word
//   req_bus   in   command, queue_id, data_in
//   rsp_bus   out  status, data_out, last
//
// enqueue, full, empty and bad queue: result register loaded in the accept cycle; CMD_NONE gives no result
// dequeue: the head is read through the memory's registered read port into the result register
// display: one memory read per stored word, through the same registered read port
// reset clears the head and tail offsets and the control state; the data memory needs no clearing
// a stalled result holds the output register; a display pauses its reads until it moves

module partitioned_multi_queue_top #(
   parameter int QUEUE_COUNT   = 4,
   parameter int SEGMENT_DEPTH = 16,
   parameter int DATA_WIDTH    = 32
) (
   input  logic       clock,
   input  logic       reset,
   pmq_req_if.sink    req_bus,
   pmq_rsp_if.source  rsp_bus
);

   localparam int STORE_DEPTH = QUEUE_COUNT * SEGMENT_DEPTH;
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int OW = $clog2(SEGMENT_DEPTH + 1);
   localparam int WW = pmq_pkg::WORD_WIDTH;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type            state_ff, state_in;
   logic [OW-1:0]        head_ff [QUEUE_COUNT];
   logic [OW-1:0]        tail_ff [QUEUE_COUNT];
   logic [AW-1:0]        addr_ff, addr_in;
   logic [OW-1:0]        rem_ff, rem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pmq_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [WW-1:0]        rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire, rsp_free, q_ok, is_full, is_empty;
   logic                 head_inc, tail_inc;
   logic [QW-1:0]        q_idx;
   logic [OW-1:0]        head_q, tail_q;
   logic [AW-1:0]        base_addr;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   pmq_store #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (DATA_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !reset && (state_ff == S_IDLE) && rsp_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign q_ok      = int'(req_bus.queue_id) < QUEUE_COUNT;
   assign q_idx     = QW'(req_bus.queue_id);
   assign head_q    = q_ok ? head_ff[q_idx] : '0;
   assign tail_q    = q_ok ? tail_ff[q_idx] : '0;
   assign is_full   = tail_q == OW'(SEGMENT_DEPTH);
   assign is_empty  = head_q == tail_q;
   assign base_addr = AW'(int'(q_idx) * SEGMENT_DEPTH);

   assign wr_addr = base_addr + AW'(tail_q);
   assign wr_data = DATA_WIDTH'($unsigned(req_bus.data_in));

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      head_inc      = 1'b0;
      tail_inc      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_bus.command != pmq_pkg::CMD_NONE)) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = pmq_pkg::ST_OK;
               if (!q_ok) begin
                  rsp_status_in = pmq_pkg::ST_BADQ;
               end else if (req_bus.command == pmq_pkg::CMD_ENQ) begin
                  if (is_full) begin
                     rsp_status_in = pmq_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_inc = 1'b1;
                  end
               end else if (is_empty) begin
                  rsp_status_in = pmq_pkg::ST_EMPTY;
               end else begin
                  // word comes back from the memory next cycle
                  rsp_valid_in = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = base_addr + AW'(head_q);
                  addr_in      = base_addr + AW'(head_q);
                  state_in     = S_READ;
                  if (req_bus.command == pmq_pkg::CMD_DEQ) begin
                     head_inc = 1'b1;
                     rem_in   = OW'(1);
                  end else begin
                     rem_in = tail_q - head_q;
                  end
               end
            end
         end
         S_READ: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pmq_pkg::ST_OK;
               rsp_data_in   = WW'(rd_data);
               rsp_last_in   = rem_ff == OW'(1);
               if (rem_ff == OW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = addr_ff + AW'(1);
                  addr_in = addr_ff + AW'(1);
                  rem_in  = rem_ff - OW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         rem_ff       <= '0;
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         rem_ff       <= rem_in;
         if (head_inc) begin
            head_ff[q_idx] <= head_q + OW'(1);
         end
         if (tail_inc) begin
            tail_ff[q_idx] <= tail_q + OW'(1);
         end
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.data_out = $signed(rsp_data_ff);
   assign rsp_bus.last     = rsp_last_ff;

   for (genvar gi = 0; gi < QUEUE_COUNT; gi++) begin : g_chk
      a_head_behind_tail: assert property (@(posedge clock) disable iff (reset)
         head_ff[gi] <= tail_ff[gi])
         else $error("head offset passed tail offset");
      a_tail_in_segment: assert property (@(posedge clock) disable iff (reset)
         tail_ff[gi] <= OW'(SEGMENT_DEPTH))
         else $error("tail offset beyond segment");
   end

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (rem_ff != '0))
      else $error("read sweep with no words left");

   a_partial_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == S_READ))
      else $error("non-final word with no display in progress");

   a_deq_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.command == pmq_pkg::CMD_DEQ) && q_ok && !is_empty)
      |=> ((state_ff == S_READ) && (rem_ff == OW'(1))))
      else $error("dequeue did not start a single read");

endmodule
